// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_POPPED   = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    localparam int PRIO_W = 16;
    localparam int DATA_W = 32;
    localparam int DEST_W = 8;

    typedef struct packed {
        logic ins;
        logic pop;
    } spq_cmd_t;

endpackage

// ===== hw/rtl/spq_ctrl.sv =====
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     op,
    input  logic     m_tready,
    output logic     s_tready,
    output logic     m_tvalid,
    output spq_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_HOLD: s_tready = m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_HOLD);
    assign cmd.ins  = accept && (op == OP_INSERT);
    assign cmd.pop  = accept && (op == OP_POP);

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = ST_HOLD;
        end
        else if (m_tready)
        begin
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/spq_datapath.sv =====
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int PAYLOAD_BITS  = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  spq_cmd_t          cmd,
    input  logic [PRIO_W-1:0] in_prio,
    input  logic [DATA_W-1:0] in_payload,
    input  logic [DEST_W-1:0] in_dest,
    output logic [1:0]        out_status,
    output logic [PRIO_W-1:0] out_prio,
    output logic [DATA_W-1:0] out_payload,
    output logic [DEST_W-1:0] out_dest
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PRIORITY_BITS-1:0] prio_reg    [DEPTH];
    logic [PAYLOAD_BITS-1:0]  payload_reg [DEPTH];
    logic [DEST_W-1:0]        dest_reg    [DEPTH];
    logic [PRIORITY_BITS-1:0] prio_next    [DEPTH];
    logic [PAYLOAD_BITS-1:0]  payload_next [DEPTH];
    logic [DEST_W-1:0]        dest_next    [DEPTH];
    logic [DEPTH-1:0]         wr;
    logic [DEPTH-1:0]         le;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     full;
    logic                     empty;
    logic                     do_ins;
    logic                     do_pop;
    logic [PRIORITY_BITS-1:0] new_prio;
    logic [PAYLOAD_BITS-1:0]  new_payload;

    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [PRIO_W-1:0]        oprio_reg;
    logic [PRIO_W-1:0]        oprio_next;
    logic [DATA_W-1:0]        opayload_reg;
    logic [DATA_W-1:0]        opayload_next;
    logic [DEST_W-1:0]        odest_reg;
    logic [DEST_W-1:0]        odest_next;

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign empty       = (count_reg == '0);
    assign do_ins      = cmd.ins && !full;
    assign do_pop      = cmd.pop && !empty;
    assign new_prio    = PRIORITY_BITS'(in_prio);
    assign new_payload = PAYLOAD_BITS'(in_payload);

    // one cell per slot, sorted with the head in slot 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic prev_le;

        assign le[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] <= new_prio);

        if (i == 0)
        begin : g_head
            assign prev_le = 1'b1;
        end
        else
        begin : g_body
            assign prev_le = le[i-1];
        end

        always_comb
        begin
            wr[i]           = 1'b0;
            prio_next[i]    = prio_reg[i];
            payload_next[i] = payload_reg[i];
            dest_next[i]    = dest_reg[i];
            if (do_ins && !le[i])
            begin
                wr[i] = 1'b1;
                if (prev_le)
                begin
                    prio_next[i]    = new_prio;
                    payload_next[i] = new_payload;
                    dest_next[i]    = in_dest;
                end
                else
                begin
                    prio_next[i]    = prio_reg[(i == 0) ? 0 : i-1];
                    payload_next[i] = payload_reg[(i == 0) ? 0 : i-1];
                    dest_next[i]    = dest_reg[(i == 0) ? 0 : i-1];
                end
            end
            else if (do_pop && (i < DEPTH - 1))
            begin
                wr[i]           = 1'b1;
                prio_next[i]    = prio_reg[(i < DEPTH - 1) ? i+1 : i];
                payload_next[i] = payload_reg[(i < DEPTH - 1) ? i+1 : i];
                dest_next[i]    = dest_reg[(i < DEPTH - 1) ? i+1 : i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr[i])
            begin
                prio_reg[i]    <= prio_next[i];
                payload_reg[i] <= payload_next[i];
                dest_reg[i]    <= dest_next[i];
            end
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        status_next   = status_reg;
        oprio_next    = oprio_reg;
        opayload_next = opayload_reg;
        odest_next    = odest_reg;
        if (cmd.ins || cmd.pop)
        begin
            oprio_next    = '0;
            opayload_next = '0;
            odest_next    = '0;
        end
        if (cmd.ins)
        begin
            status_next = full ? STAT_FULL : STAT_INSERTED;
            if (!full)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (cmd.pop)
        begin
            status_next = empty ? STAT_EMPTY : STAT_POPPED;
            if (!empty)
            begin
                count_next    = count_reg - 1'b1;
                oprio_next    = PRIO_W'(prio_reg[0]);
                opayload_next = DATA_W'(payload_reg[0]);
                odest_next    = dest_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        oprio_reg    <= oprio_next;
        opayload_reg <= opayload_next;
        odest_reg    <= odest_next;
    end

    assign out_status  = status_reg;
    assign out_prio    = oprio_reg;
    assign out_payload = opayload_reg;
    assign out_dest    = odest_reg;

endmodule

// ===== hw/rtl/stable_priority_queue_core.sv =====
// stable sorted priority queue, smallest priority leaves first, ties in arrival order
// s_* channel: one beat per command; s_tuser selects insert or pop,
//   s_tdata carries priority, payload and destination of an insert
// m_* channel: exactly one result beat per command; m_tuser gives the status
//   (inserted, popped, empty on pop, full and insert dropped), m_tdata the
//   popped entry or zero
// latency: the result beat is valid in the cycle after the command is taken
// throughput: one command per cycle while m_tready is high; every cell of the sorted
//   register array compares its priority against the new key in parallel, so an
//   insert or a pop finishes at its accept edge
// the store holds DEPTH entries; an insert into a full store is dropped
// stall: the result sits in an output register; while the receiver holds
//   m_tready low, s_tready is low too, and a new command is taken in the same
//   cycle the waiting result leaves
// reset: the store is emptied at once and both channels go idle; no clearing
//   pass is needed
module stable_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int PAYLOAD_BITS  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // entry_priority, entry_payload, entry_destination
    input  logic [0:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_priority, out_payload, out_destination
    output logic [1:0]  m_tuser    // status
);

    spq_cmd_t          cmd;
    logic [1:0]        out_status;
    logic [PRIO_W-1:0] out_prio;
    logic [DATA_W-1:0] out_payload;
    logic [DEST_W-1:0] out_dest;

    spq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tuser[0]),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    spq_datapath #(
        .DEPTH         (DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_prio     (s_tdata[15:0]),
        .in_payload  (s_tdata[47:16]),
        .in_dest     (s_tdata[55:48]),
        .out_status  (out_status),
        .out_prio    (out_prio),
        .out_payload (out_payload),
        .out_dest    (out_dest)
    );

    assign m_tdata = {out_dest, out_payload, out_prio};
    assign m_tuser = out_status;

endmodule

// ===== hw/rtl/spq_checker.sv =====
module spq_checker
    import spq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a taken command always yields a result beat next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
    else $error("no result beat after accepted command");

    // a stalled result blocks new commands
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
    else $error("command taken while result stalled");

    // only a popped result carries entry data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_POPPED) |-> (m_tdata == '0))
    else $error("non-pop result carries data");

    // an insert never reports a pop status
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == OP_INSERT)
        |=> (m_tuser == STAT_INSERTED) || (m_tuser == STAT_FULL))
    else $error("insert gave a pop status");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/stable_priority_queue_core_tb.sv =====
`timescale 1ns / 100ps

module stable_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int DEPTH = 16;
    localparam int RANDOM_ITEMS = 800;

    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [DATA_W-1:0] payload;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DEST_W-1:0] dest;
        logic [DATA_W-1:0] payload;
        logic [PRIO_W-1:0] prio;
    } result_t;

    typedef struct {
        logic    op;
        entry_t  item;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // entry_priority, entry_payload, entry_destination
    logic [0:0]  s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // out_priority, out_payload, out_destination
    logic [1:0]  m_tuser;   // status

    entry_t    sorted_store[$];
    result_t   pending_results[$];
    stim_row_t directed_rows[$];
    bit        failed;
    bit        no_idle;
    bit        hold_req;
    int        hold_left;

    stable_priority_queue_core #(
        .DEPTH(DEPTH),
        .PRIORITY_BITS(PRIO_W),
        .PAYLOAD_BITS(DATA_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_INSERT;
        m_tready = 1'b0;
        failed = 1'b0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t predict_queue_result(logic op, entry_t item);
        result_t r;
        int pos;
        entry_t head;
        r = '0;
        if (op == OP_INSERT)
        begin
            if (sorted_store.size() >= DEPTH)
                r.status = STAT_FULL;
            else
            begin
                pos = 0;
                while (pos < sorted_store.size() && sorted_store[pos].prio <= item.prio)
                    pos++;
                sorted_store.insert(pos, item);
                r.status = STAT_INSERTED;
            end
        end
        else if (sorted_store.size() == 0)
            r.status = STAT_EMPTY;
        else
        begin
            head = sorted_store.pop_front();
            r.status = STAT_POPPED;
            r.prio = head.prio;
            r.payload = head.payload;
            r.dest = head.dest;
        end
        return r;
    endfunction

    task automatic add_row(logic op, entry_t item, bit typed, result_t want);
        stim_row_t row;
        row.op = op;
        row.item = item;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_beat(logic op, entry_t item, bit typed, result_t want);
        result_t predicted;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {item.dest, item.payload, item.prio};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_queue_result(op, item);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left <= 80;
                m_tready <= 1'b0;
            end
            else if (no_idle)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 38);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, status %0d", $time, m_tuser);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    failed = 1'b1;
                end
                if (m_tdata[15:0] !== want.prio)
                begin
                    $display("%0t: priority expected %0h actual %0h",
                             $time, want.prio, m_tdata[15:0]);
                    failed = 1'b1;
                end
                if (m_tdata[47:16] !== want.payload)
                begin
                    $display("%0t: payload expected %0h actual %0h",
                             $time, want.payload, m_tdata[47:16]);
                    failed = 1'b1;
                end
                if (m_tdata[55:48] !== want.dest)
                begin
                    $display("%0t: destination expected %0h actual %0h",
                             $time, want.dest, m_tdata[55:48]);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        entry_t  item;
        result_t want;
        logic    op;
        int      mode;
        int      pick;

        // pop on empty, extremes, equal priorities in arrival order
        add_row(OP_POP, '0, 1'b1, '{STAT_EMPTY, 8'h00, 32'h0, 16'h0});
        add_row(OP_INSERT, '{8'hff, 32'hffff_ffff, 16'hffff}, 1'b1, '{STAT_INSERTED, 8'h0, 32'h0, 16'h0});
        add_row(OP_INSERT, '{8'h00, 32'h0000_0000, 16'h0000}, 1'b1, '{STAT_INSERTED, 8'h0, 32'h0, 16'h0});
        add_row(OP_INSERT, '{8'h5a, 32'h0000_0001, 16'h0000}, 1'b1, '{STAT_INSERTED, 8'h0, 32'h0, 16'h0});
        add_row(OP_POP, '0, 1'b1, '{STAT_POPPED, 8'h00, 32'h0000_0000, 16'h0000});
        add_row(OP_POP, '0, 1'b1, '{STAT_POPPED, 8'h5a, 32'h0000_0001, 16'h0000});
        add_row(OP_POP, '0, 1'b1, '{STAT_POPPED, 8'hff, 32'hffff_ffff, 16'hffff});
        add_row(OP_POP, '0, 1'b1, '{STAT_EMPTY, 8'h00, 32'h0, 16'h0});
        // fill to capacity with ties, then one dropped insert
        for (int k = 0; k < DEPTH; k++)
            add_row(OP_INSERT, '{k[7:0], 32'h1000_0000 + k, 16'((k * 5) % 7)}, 1'b0, '0);
        add_row(OP_INSERT, '{8'ha5, 32'hdead_beef, 16'h0001}, 1'b1, '{STAT_FULL, 8'h0, 32'h0, 16'h0});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].op, directed_rows[i].item,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 100)
                hold_req = 1'b1;
            no_idle = (i >= 300 && i < 450);
            if (i == 500)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            mode = (i / 40) % 3;
            pick = $urandom_range(0, 99);
            if (mode == 0)
                op = (pick < 80) ? OP_INSERT : OP_POP;
            else if (mode == 1)
                op = (pick < 80) ? OP_POP : OP_INSERT;
            else
                op = (pick < 50) ? OP_INSERT : OP_POP;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                item.prio = 16'($urandom_range(0, 7));
            else if (pick < 60)
                item.prio = 16'h0000;
            else if (pick < 70)
                item.prio = 16'hffff;
            else
                item.prio = 16'($urandom);
            item.payload = $urandom;
            item.dest = 8'($urandom_range(0, 255));
            want = '0;
            send_beat(op, item, 1'b0, want);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
